// File: sv/mavw_pkg.sv
`default_nettype none

package mavw_pkg;

  // Width of one Q8.8 sample and of one averaged result.
  localparam int unsigned DataW = 16;

  typedef logic signed [DataW-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

endpackage

`default_nettype wire

// File: sv/moving_average_warmup.sv
// Moving average with warm-up. Each transfer on the input channel carries one
// signed Q8.8 temperature sample and produces exactly one transfer on the
// output channel: the mean of the last WINDOW samples, truncated toward zero,
// and a filled flag that is high once WINDOW samples have been seen. Before
// that, the mean is taken over the samples received so far, the new one
// included. Samples live in a single-port ring buffer next to a running sum.
// One item is worked on at a time. The new sample is written and the oldest
// one read at the input transfer itself. After that the sum is updated, the
// divider is started, the bit-serial restoring divider, which sets the rate,
// works through the quotient bits, its finish is seen and, once the output
// register is free, the result is loaded into it.
// The next sample is taken as soon as the previous result sits in the output
// register, even if the consumer has not yet taken it.

`default_nettype none

module moving_average_warmup #(
  parameter int unsigned WINDOW = 50
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mavw_pkg::sample_t  sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mavw_pkg::sample_t       average_o,
  output logic                    filled_o
);
  import mavw_pkg::*;

  // Ring buffer index, sample count (0..WINDOW) and exact running sum widths.
  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = DataW + $clog2(WINDOW);

  state_e state_q, state_d;

  logic [SlotW-1:0]       slot_q, slot_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  sample_t                sample_q;
  sample_t                oldest;
  logic                   neg_q;

  logic                   in_xfer;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  logic [SumW-1:0]        div_quot;
  logic [SumW-1:0]        sum_mag;
  logic                   out_valid_q, out_valid_d;
  sample_t                average_q, average_d;
  logic                   filled_q, filled_d;
  logic                   window_full;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign window_full = (fill_q == CntW'(WINDOW));

  // The new sample is written into the slot of the oldest one while the
  // oldest is read out in the same cycle.
  mavw_ram #(
    .Depth (WINDOW),
    .AddrW (SlotW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (in_xfer),
    .addr_i  (slot_q),
    .wdata_i (sample_i),
    .rdata_o (oldest)
  );

  // The divider works on magnitudes; the sign is restored on the way out.
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  mavw_div #(
    .NumW (SumW),
    .DenW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_START;
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_d = ST_OUTPUT;
      ST_OUTPUT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    div_start   = (state_q == ST_START);
    slot_d      = slot_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    average_d   = average_q;
    filled_d    = filled_q;
    case (state_q)
      ST_UPDATE: begin
        // Once the window is full, the oldest sample leaves the sum.
        if (window_full) begin
          sum_d = sum_q + SumW'(sample_q) - SumW'(oldest);
        end else begin
          sum_d  = sum_q + SumW'(sample_q);
          fill_d = fill_q + 1'b1;
        end
        if (slot_q == SlotW'(WINDOW - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          average_d   = neg_q ? DataW'(-div_quot[DataW-1:0]) : div_quot[DataW-1:0];
          filled_d    = window_full;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
    end
    if (div_start) begin
      neg_q <= sum_q[SumW-1];
    end
    average_q <= average_d;
    filled_q  <= filled_d;
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign filled_o    = filled_q;

endmodule

`default_nettype wire

// File: sv/mavw_ram.sv
`default_nettype none

module mavw_ram #(
  parameter int unsigned Depth = 50,
  parameter int unsigned AddrW = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [AddrW-1:0]        addr_i,
  input  wire mavw_pkg::sample_t       wdata_i,
  output mavw_pkg::sample_t            rdata_o
);
  import mavw_pkg::*;

  sample_t mem_q [Depth];
  sample_t rdata_q;

  // Read-first: the read returns the entry as it was before this write.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/mavw_div.sv
`default_nettype none

module mavw_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NumW-1:0]   dividend_i,
  input  wire logic [DenW-1:0]   divisor_i,
  output logic                   done_o,
  output logic [NumW-1:0]        quotient_o
);
  import mavw_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   rem_shift;
  logic [DenW:0]   rem_diff;

  // One restoring step per cycle; quotient bits enter where dividend bits leave.
  always_comb begin
    rem_shift = {rem_q, num_q[NumW-1]};
    rem_diff  = rem_shift - {1'b0, den_q};
    num_d     = num_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, den_q}) begin
        rem_d = rem_diff[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

// File: test/mavw_checker.sv
module mavw_checker #(
  parameter int unsigned WINDOW = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  mavw_pkg::sample_t sample_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  mavw_pkg::sample_t average_i,
  input  logic              filled_i,
  output int unsigned       awaiting_o,
  output int unsigned       fault_count_o
);
  import mavw_pkg::*;

  typedef struct {
    sample_t average;
    logic    filled;
  } window_mean_t;

  // Shadow copy of the sample history, kept as a ring with a running total.
  sample_t      history_q [WINDOW];
  int unsigned  slot_q;
  int unsigned  held_q;
  int           total_q;
  int unsigned  faults;
  window_mean_t pending_means [$];

  initial faults = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    window_mean_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) history_q[i] = '0;
      slot_q  = 0;
      held_q  = 0;
      total_q = 0;
      pending_means.delete();
      awaiting_o    <= 0;
      fault_count_o <= faults;
    end else begin
      // A result can never belong to a sample taken at the same edge, so the
      // output side is checked before the new sample is folded in.
      if (out_valid_i && out_ready_i) begin
        if (pending_means.size() == 0) begin
          faults++;
          if (faults <= 10) begin
            $display("checker: unexpected result average %0d filled %0b",
                     average_i, filled_i);
          end
        end else begin
          want = pending_means.pop_front();
          if (want.average !== average_i || want.filled !== filled_i) begin
            faults++;
            if (faults <= 10) begin
              $display("checker: average expected %0d got %0d, filled expected %0b got %0b",
                       want.average, average_i, want.filled, filled_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        // The oldest sample leaves the total only once the window is full.
        if (held_q < WINDOW) begin
          held_q++;
        end else begin
          total_q -= history_q[slot_q];
        end
        history_q[slot_q] = sample_i;
        total_q += sample_i;
        slot_q = (slot_q == WINDOW - 1) ? 0 : slot_q + 1;
        // Integer division truncates toward zero, as the block does.
        want.average = sample_t'(total_q / int'(held_q));
        want.filled  = (held_q == WINDOW);
        pending_means.push_back(want);
      end
      awaiting_o    <= pending_means.size();
      fault_count_o <= faults;
    end
  end

endmodule

// File: test/tb.sv
// Testbench top for the moving average block. It drives samples on the input
// channel, takes results on the output channel and leaves all prediction and
// comparison to the checker instantiated next to the block. The verdict is
// given here once every expected mean has been delivered.

module tb;
  import mavw_pkg::*;

  localparam int unsigned WINDOW      = 50;
  localparam int unsigned SAMPLE_GOAL = 1450;
  // Longest hold on the output side; it is far longer than one item takes,
  // so the block fills its output register and refuses further samples.
  localparam int unsigned LONG_HOLD   = 500;

  // Shapes of the random sample runs.
  typedef enum int unsigned {
    RUN_UNIFORM,
    RUN_TOP,
    RUN_BOTTOM,
    RUN_NEAR_ZERO,
    RUN_SWING,
    RUN_NEG_SMALL
  } run_shape_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sample_t     sample;
  logic        out_valid;
  logic        out_ready;
  sample_t     average;
  logic        filled;
  int unsigned awaiting;
  int unsigned fault_count;

  // Both sides skip their random gaps while this is set, so that stretches
  // of back-to-back transfers occur as well.
  bit          steady = 1'b0;
  int unsigned sent = 0;

  always #10 clk = ~clk;

  moving_average_warmup #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .average_o   (average),
    .filled_o    (filled)
  );

  mavw_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_i      (sample),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .average_i     (average),
    .filled_i      (filled),
    .awaiting_o    (awaiting),
    .fault_count_o (fault_count)
  );

  // Offers one sample after a random gap and returns at the edge on which it
  // was transferred. Valid is only lowered when a gap is taken, so a sample
  // that follows directly keeps valid high throughout.
  task automatic offer_sample(input sample_t value);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Output side: a random stall before each result, and twice a long hold
  // while the input side keeps offering samples.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) begin
        stall = LONG_HOLD;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    sample_t     opening [$];
    run_shape_e  shape;
    int unsigned run_len;
    sample_t     value;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    sample   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The warm-up phase only happens once, so the directed samples go first.
    // The very first sample is the positive extreme and must come back as is.
    // The following ones give small negative totals over few samples, where
    // truncation toward zero differs from flooring, and alternating bit
    // patterns on every sample bit.
    opening = '{16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                -16'sd2, -16'sd3, 16'sh5555, -16'sh5556, 16'sh00FF, -16'sh0100,
                16'sh0001, -16'sh7FFF, 16'sh7FFF, -16'sd7, -16'sd5, 16'sd4};
    foreach (opening[i]) offer_sample(opening[i]);

    // Random runs of varied shape. Runs longer than the window of a single
    // extreme drive the running total to its largest and smallest values,
    // and the ring wraps many times over.
    while (sent < SAMPLE_GOAL) begin
      shape   = run_shape_e'($urandom_range(0, 5));
      run_len = $urandom_range(5, 2 * WINDOW);
      steady  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len && sent < SAMPLE_GOAL; k++) begin
        case (shape)
          RUN_TOP:       value = 16'sh7FFF - sample_t'($urandom_range(0, 1));
          RUN_BOTTOM:    value = -16'sh8000 + sample_t'($urandom_range(0, 1));
          RUN_NEAR_ZERO: value = sample_t'(int'($urandom_range(0, 8)) - 4);
          RUN_SWING:     value = (k % 2 == 0) ? 16'sh7FFF : -16'sh8000;
          RUN_NEG_SMALL: value = sample_t'(-int'($urandom_range(1, 300)));
          default:       value = sample_t'($urandom_range(0, 16'hFFFF));
        endcase
        offer_sample(value);
      end
    end
    in_valid <= 1'b0;
    steady    = 1'b0;

    // Wait until the checker awaits no more means.
    do @(posedge clk); while (awaiting != 0);
    repeat (60) @(posedge clk);

    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
